FILE: hw/rtl/tlik_pkg.sv
// Shared types, constants and helpers for the two-link arm IK pipeline.
`timescale 1ns / 1ps
package tlik_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ANG_FRAC      = 24;
  localparam int DIV_STEPS     = 30;
  localparam int SQRT_STEPS    = 32;
  localparam int CORDIC_STEPS  = 31;
  localparam int NORM_STEPS    = 6;
  localparam int ATAN_LAT      = 1 + NORM_STEPS + CORDIC_STEPS + 1;
  localparam int ANG_W         = 33;

  localparam logic signed [ANG_W-1:0] DEG90  = 33'sd1509949440;
  localparam logic signed [ANG_W-1:0] DEG180 = 33'sd3019898880;
  localparam logic [30:0] COS_ONE = 31'h4000_0000;
  localparam logic [63:0] COS_ONE_SQ = 64'd1 << 60;

  // atan(2^-i) in degrees, Q.24
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1
  };

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_CONFIG  = 2'd1,
    ST_ZERO_LINK   = 2'd2,
    ST_UNREACHABLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ARM_READY = 2'd0,
    REG_UPPER_LEN = 2'd1,
    REG_LOWER_LEN = 2'd2,
    REG_SHOULDER  = 2'd3
  } cfg_reg_t;

  // Per-item side data that rides alongside the datapath
  typedef struct packed {
    status_t            status;
    logic               up;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z1;
    logic [63:0]        rr;
    logic               neg;
    logic               eq;
    logic [30:0]        cm;
  } item_t;

  // Q.24 degrees to Q.sh-less format, round half away from zero, saturate
  function automatic logic [25:0] round_sat(input logic signed [34:0] a,
                                            input int sh, input int width);
    logic        neg;
    logic [34:0] m;
    logic [34:0] lim;
    logic [34:0] r;
    neg = a[34];
    m   = neg ? 35'(-a) : 35'(a);
    if (sh > 0) m = (m + (35'd1 << (sh - 1))) >> sh;
    lim = (35'd1 << (width - 1)) - 35'd1;
    if (!neg && m > lim) m = lim;
    if (neg && m > lim + 35'd1) m = lim + 35'd1;
    r = neg ? 35'(-m) : m;
    return r[25:0];
  endfunction

endpackage

FILE: hw/rtl/tlik_div_cell.sv
// One restoring-division step: shifts the remainder and emits one quotient bit.
`timescale 1ns / 1ps
module tlik_div_cell import tlik_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [62:0] den_in,
  input  logic [DIV_STEPS-1:0] q_in,
  output logic [63:0] rem_out,
  output logic [62:0] den_out,
  output logic [DIV_STEPS-1:0] q_out
);
  logic [63:0] rem2;
  logic        ge;

  assign rem2 = {rem_in[62:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem2 - {1'b0, den_in} : rem2;
      den_out <= den_in;
      q_out   <= {q_in[DIV_STEPS-2:0], ge};
    end
  end
endmodule

FILE: hw/rtl/tlik_sqrt_cell.sv
// One step of the digit-by-digit integer square root.
`timescale 1ns / 1ps
module tlik_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  input  logic [63:0] res_in,
  output logic [63:0] n_out,
  output logic [63:0] res_out
);
  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic        ge;

  assign trial = res_in + BIT;
  assign ge    = n_in >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      n_out   <= ge ? n_in - trial : n_in;
      res_out <= ge ? (res_in >> 1) + BIT : res_in >> 1;
    end
  end
endmodule

FILE: hw/rtl/tlik_cordic_cell.sv
// One CORDIC vectoring micro-rotation, angle accumulated in degrees Q.24.
`timescale 1ns / 1ps
module tlik_cordic_cell import tlik_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [63:0]      cx_in,
  input  logic signed [63:0]      cy_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [63:0]      cx_out,
  output logic signed [63:0]      cy_out,
  output logic signed [ANG_W-1:0] z_out
);
  logic signed [63:0]      dx, dy;
  logic signed [ANG_W-1:0] ang;

  assign dx  = cy_in >>> STEP;
  assign dy  = cx_in >>> STEP;
  assign ang = signed'({3'b000, ATAN_TAB[STEP]});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!cy_in[63]) begin
        cx_out <= cx_in + dx;
        cy_out <= cy_in - dy;
        z_out  <= z_in + ang;
      end else begin
        cx_out <= cx_in - dx;
        cy_out <= cy_in + dy;
        z_out  <= z_in - ang;
      end
    end
  end
endmodule

FILE: hw/rtl/tlik_atan2.sv
// Pipelined four-quadrant atan2 in degrees: normaliser, CORDIC row, fold-out.
`timescale 1ns / 1ps
module tlik_atan2 import tlik_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [63:0]      y,
  input  logic signed [63:0]      x,
  output logic signed [ANG_W-1:0] ang
);
  typedef struct packed {
    logic both0;
    logic ay0;
    logic ax0;
    logic xneg;
    logic yneg;
  } aflags_t;

  localparam int FL_N = NORM_STEPS + CORDIC_STEPS + 1;

  logic [63:0] ax, ay, mx;
  logic [1:0]  rs;
  aflags_t     fl_c;
  aflags_t     fl [FL_N];

  logic [63:0] nx [NORM_STEPS+1];
  logic [63:0] ny [NORM_STEPS+1];
  logic [63:0] nm [NORM_STEPS+1];

  logic signed [63:0]      cxa [CORDIC_STEPS+1];
  logic signed [63:0]      cya [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] za  [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] zc, a0, a1;

  assign ax = x[63] ? 64'(-x) : 64'(x);
  assign ay = y[63] ? 64'(-y) : 64'(y);
  assign mx = (ax > ay) ? ax : ay;
  // coarse right shift so the larger magnitude is below 2^61
  assign rs = mx[63] ? 2'd3 : mx[62] ? 2'd2 : mx[61] ? 2'd1 : 2'd0;

  assign fl_c.both0 = (ax == '0) && (ay == '0);
  assign fl_c.ay0   = (ay == '0);
  assign fl_c.ax0   = (ax == '0);
  assign fl_c.xneg  = x[63];
  assign fl_c.yneg  = y[63];

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= ax >> rs;
      ny[0] <= ay >> rs;
      nm[0] <= mx >> rs;
      fl[0] <= fl_c;
      for (int k = 1; k < FL_N; k++) fl[k] <= fl[k-1];
    end
  end

  // binary left normalisation: 32, 16, 8, 4, 2, 1
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic lift;
    assign lift = nm[j] < (64'd1 << (61 - SH));
    always_ff @(posedge clk) begin
      if (en) begin
        nx[j+1] <= lift ? nx[j] << SH : nx[j];
        ny[j+1] <= lift ? ny[j] << SH : ny[j];
        nm[j+1] <= lift ? nm[j] << SH : nm[j];
      end
    end
  end

  assign cxa[0] = signed'(nx[NORM_STEPS]);
  assign cya[0] = signed'(ny[NORM_STEPS]);
  assign za[0]  = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    tlik_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .en     (en),
      .cx_in  (cxa[i]),
      .cy_in  (cya[i]),
      .z_in   (za[i]),
      .cx_out (cxa[i+1]),
      .cy_out (cya[i+1]),
      .z_out  (za[i+1])
    );
  end

  always_comb begin
    zc = za[CORDIC_STEPS];
    if (zc < 0) zc = '0;
    if (zc > DEG90) zc = DEG90;
    if (fl[FL_N-1].both0 || fl[FL_N-1].ay0) a0 = '0;
    else if (fl[FL_N-1].ax0) a0 = DEG90;
    else a0 = zc;
    a1 = fl[FL_N-1].xneg ? DEG180 - a0 : a0;
    if (fl[FL_N-1].both0) a1 = '0;
  end

  always_ff @(posedge clk) begin
    if (en) ang <= fl[FL_N-1].yneg ? -a1 : a1;
  end
endmodule

FILE: hw/rtl/two_link_arm_inverse_kinematics.sv
// Top level: two-link arm inverse kinematics with base yaw, fully pipelined.
`timescale 1ns / 1ps
// Solves a target point (x, y, z) for base yaw, shoulder and elbow angles in
// degrees (Q.FRAC_BITS) from link lengths l1, l2 and shoulder height z0 held
// in the configuration registers; raise_elbow negates the elbow solution. One
// transfer is taken per clock while the pipe is not stalled, and results come
// out in order through 115 register stages, input register included; these are
// set by the chain of cells: 30 restoring-divide cells for the elbow cosine,
// 32 square-root cells (sine and horizontal reach side by side), and four
// 39-stage atan2 units (normaliser plus 31 CORDIC cells) in parallel, with a
// handful of multiply/add stages between them. The whole pipe moves together
// and stalls only while the output register holds an untaken result; the
// input register may still be filled when it is empty. Status reports not
// configured, zero link or unreachable target; all angles then read zero. The
// user must write configuration only with the pipe empty; it is not enforced.
module two_link_arm_inverse_kinematics import tlik_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic               raise_elbow,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] base_deg,
  output logic signed [25:0] shoulder_deg,
  output logic signed [24:0] elbow_deg,
  output logic [1:0]         status
);
  localparam int LAT = 1 + 6 + DIV_STEPS + 3 + SQRT_STEPS + 2 + ATAN_LAT + 2;
  localparam int RSH = ANG_FRAC - FRAC_BITS;

  // configuration registers
  logic               arm_ready;
  logic [30:0]        l1, l2;
  logic signed [31:0] z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_ready <= 1'b0;
      l1        <= '0;
      l2        <= '0;
      z0        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ARM_READY: arm_ready <= cfg_data[0];
        REG_UPPER_LEN: l1 <= cfg_data[30:0];
        REG_LOWER_LEN: l2 <= cfg_data[30:0];
        REG_SHOULDER:  z0 <= cfg_data;
        default:       arm_ready <= arm_ready;
      endcase
    end
  end

  // pipe control: one valid bit per stage, all stages past the input register advance together
  logic [LAT-1:0] v;
  logic           adv, en0;

  assign adv       = !v[LAT-1] || out_ready;
  assign en0       = adv || !v[0];
  assign in_ready  = en0;
  assign out_valid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en0) v[0] <= in_valid;
      if (adv) v[LAT-1:1] <= v[LAT-2:0];
    end
  end

  // input register
  logic signed [31:0] x0, y0, tz0;
  logic               up0;

  always_ff @(posedge clk) begin
    if (en0) begin
      x0  <= target_x;
      y0  <= target_y;
      tz0 <= target_z;
      up0 <= raise_elbow;
    end
  end

  // A: magnitudes, height above shoulder, config checks
  logic signed [32:0] z1_c;
  item_t              ita_n, it_a;
  logic [31:0]        ux_a, uy_a, uz_a;

  assign z1_c = 33'(tz0) - 33'(z0);

  always_comb begin
    ita_n        = '0;
    ita_n.status = !arm_ready ? ST_NOT_CONFIG :
                   (l1 == '0 || l2 == '0) ? ST_ZERO_LINK : ST_OK;
    ita_n.up     = up0;
    ita_n.x      = x0;
    ita_n.y      = y0;
    ita_n.z1     = z1_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_a <= ita_n;
      ux_a <= x0[31] ? 32'(-x0) : 32'(x0);
      uy_a <= y0[31] ? 32'(-y0) : 32'(y0);
      uz_a <= z1_c[32] ? 32'(-z1_c) : z1_c[31:0];
    end
  end

  // B: squares and link products
  item_t       it_b;
  logic [63:0] ux2_b, uy2_b, uz2_b, l1sq_b, l2sq_b, l12_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      it_b   <= it_a;
      ux2_b  <= 64'(ux_a) * 64'(ux_a);
      uy2_b  <= 64'(uy_a) * 64'(uy_a);
      uz2_b  <= 64'(uz_a) * 64'(uz_a);
      l1sq_b <= 64'(l1) * 64'(l1);
      l2sq_b <= 64'(l2) * 64'(l2);
      l12_b  <= 64'(l1) * 64'(l2);
    end
  end

  // C: r^2, l1^2 + l2^2, 2 l1 l2
  item_t       itc_n, it_c;
  logic [63:0] uz2_c, ssum_c;
  logic [62:0] den_c;

  always_comb begin
    itc_n    = it_b;
    itc_n.rr = ux2_b + uy2_b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_c   <= itc_n;
      uz2_c  <= uz2_b;
      ssum_c <= l1sq_b + l2sq_b;
      den_c  <= {l12_b[61:0], 1'b0};
    end
  end

  // D: squared distance, carry out flags an unreachable target
  item_t       it_d;
  logic [64:0] d2_d;
  logic [63:0] ssum_d;
  logic [62:0] den_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      it_d   <= it_c;
      d2_d   <= {1'b0, it_c.rr} + {1'b0, uz2_c};
      ssum_d <= ssum_c;
      den_d  <= den_c;
    end
  end

  // E: |numerator| and its sign
  item_t       ite_n, it_e;
  logic        ge_d;
  logic [63:0] mag_e;
  logic        ovf_e;
  logic [62:0] den_e;

  assign ge_d = d2_d[63:0] >= ssum_d;

  always_comb begin
    ite_n     = it_d;
    ite_n.neg = !ge_d;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_e  <= ite_n;
      mag_e <= ge_d ? d2_d[63:0] - ssum_d : ssum_d - d2_d[63:0];
      ovf_e <= d2_d[64];
      den_e <= den_d;
    end
  end

  // F: reach test
  item_t       itf_n, it_f;
  logic [63:0] rem_f;
  logic [62:0] den_f;

  always_comb begin
    itf_n    = it_e;
    itf_n.eq = (mag_e == {1'b0, den_e});
    if (it_e.status == ST_OK && (ovf_e || mag_e > {1'b0, den_e}))
      itf_n.status = ST_UNREACHABLE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_f  <= itf_n;
      rem_f <= mag_e;
      den_f <= den_e;
    end
  end

  // cosine magnitude in Q1.30 through the divider row
  logic [63:0]          rem_w [DIV_STEPS+1];
  logic [62:0]          den_w [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_w   [DIV_STEPS+1];
  item_t                div_it [DIV_STEPS];

  assign rem_w[0] = rem_f;
  assign den_w[0] = den_f;
  assign q_w[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tlik_div_cell u_div (
      .clk     (clk),
      .en      (adv),
      .rem_in  (rem_w[k]),
      .den_in  (den_w[k]),
      .q_in    (q_w[k]),
      .rem_out (rem_w[k+1]),
      .den_out (den_w[k+1]),
      .q_out   (q_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_it[0] <= it_f;
      for (int k = 1; k < DIV_STEPS; k++) div_it[k] <= div_it[k-1];
    end
  end

  // G: pick cosine, H: square it, I: 1 - c^2
  item_t       itg_n, it_g, it_h, it_i;
  logic [63:0] cmsq_h, sq_i;

  always_comb begin
    itg_n    = div_it[DIV_STEPS-1];
    itg_n.cm = itg_n.eq ? COS_ONE : {1'b0, q_w[DIV_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_g   <= itg_n;
      it_h   <= it_g;
      cmsq_h <= 64'(it_g.cm) * 64'(it_g.cm);
      it_i   <= it_h;
      sq_i   <= COS_ONE_SQ - cmsq_h;
    end
  end

  // two square-root rows side by side: elbow sine and horizontal reach
  logic [63:0] sn_n [SQRT_STEPS+1];
  logic [63:0] sn_r [SQRT_STEPS+1];
  logic [63:0] rh_n [SQRT_STEPS+1];
  logic [63:0] rh_r [SQRT_STEPS+1];
  item_t       sq_it [SQRT_STEPS];

  assign sn_n[0] = sq_i;
  assign sn_r[0] = '0;
  assign rh_n[0] = it_i.rr;
  assign rh_r[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tlik_sqrt_cell #(.STEP(k)) u_sin (
      .clk     (clk),
      .en      (adv),
      .n_in    (sn_n[k]),
      .res_in  (sn_r[k]),
      .n_out   (sn_n[k+1]),
      .res_out (sn_r[k+1])
    );
    tlik_sqrt_cell #(.STEP(k)) u_reach (
      .clk     (clk),
      .en      (adv),
      .n_in    (rh_n[k]),
      .res_in  (rh_r[k]),
      .n_out   (rh_n[k+1]),
      .res_out (rh_r[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_it[0] <= it_i;
      for (int k = 1; k < SQRT_STEPS; k++) sq_it[k] <= sq_it[k-1];
    end
  end

  // J: l2 sin, l2 |cos|
  item_t       it_j;
  logic [30:0] sn_j;
  logic [31:0] r_j;
  logic [63:0] ky0_j, p_j;

  always_ff @(posedge clk) begin
    if (adv) begin
      it_j  <= sq_it[SQRT_STEPS-1];
      sn_j  <= sn_r[SQRT_STEPS][30:0];
      r_j   <= rh_r[SQRT_STEPS][31:0];
      ky0_j <= 64'(l2) * 64'(sn_r[SQRT_STEPS][30:0]);
      p_j   <= 64'(l2) * 64'(sq_it[SQRT_STEPS-1].cm);
    end
  end

  // K: atan2 operand pairs
  item_t              it_k;
  logic [63:0]        l1s;
  logic signed [63:0] ely_k, elx_k, a1y_k, a1x_k, a2y_k, a2x_k, by_k, bx_k;

  assign l1s = {3'b000, l1, 30'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      it_k  <= it_j;
      ely_k <= signed'(64'(sn_j));
      elx_k <= it_j.neg ? -signed'(64'(it_j.cm)) : signed'(64'(it_j.cm));
      a1y_k <= 64'(it_j.z1);
      a1x_k <= signed'(64'(r_j));
      a2y_k <= it_j.up ? -signed'(ky0_j) : signed'(ky0_j);
      a2x_k <= it_j.neg ? signed'(l1s - p_j) : signed'(l1s + p_j);
      by_k  <= 64'(it_j.y);
      bx_k  <= 64'(it_j.x);
    end
  end

  logic signed [ANG_W-1:0] ang_el, ang_a1, ang_a2, ang_b;
  item_t                   at_it [ATAN_LAT];

  tlik_atan2 u_at_elbow (.clk(clk), .en(adv), .y(ely_k), .x(elx_k), .ang(ang_el));
  tlik_atan2 u_at_reach (.clk(clk), .en(adv), .y(a1y_k), .x(a1x_k), .ang(ang_a1));
  tlik_atan2 u_at_link  (.clk(clk), .en(adv), .y(a2y_k), .x(a2x_k), .ang(ang_a2));
  tlik_atan2 u_at_base  (.clk(clk), .en(adv), .y(by_k),  .x(bx_k),  .ang(ang_b));

  always_ff @(posedge clk) begin
    if (adv) begin
      at_it[0] <= it_k;
      for (int k = 1; k < ATAN_LAT; k++) at_it[k] <= at_it[k-1];
    end
  end

  // M: shoulder difference, elbow sign
  item_t              it_m;
  logic signed [34:0] el_m, sh_m, b_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      it_m <= at_it[ATAN_LAT-1];
      el_m <= at_it[ATAN_LAT-1].up ? -35'(ang_el) : 35'(ang_el);
      sh_m <= 35'(ang_a1) - 35'(ang_a2);
      b_m  <= 35'(ang_b);
    end
  end

  // N: round to output format, zero on error
  logic [25:0] rb, rsh, rel;
  logic        ok_m;

  assign rb   = round_sat(b_m, RSH, 25);
  assign rsh  = round_sat(sh_m, RSH, 26);
  assign rel  = round_sat(el_m, RSH, 25);
  assign ok_m = (it_m.status == ST_OK);

  always_ff @(posedge clk) begin
    if (adv) begin
      base_deg     <= ok_m ? signed'(rb[24:0]) : '0;
      shoulder_deg <= ok_m ? signed'(rsh) : '0;
      elbow_deg    <= ok_m ? signed'(rel[24:0]) : '0;
      status       <= it_m.status;
    end
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> base_deg == '0 && shoulder_deg == '0 &&
      elbow_deg == '0)
    else $error("angles not zero on error status");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v[LAT-1:1]))
    else $error("pipe moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented straight after reset");

endmodule
